/* design/sie_pkg.sv */
package sie_pkg;

   localparam int SET_CAPACITY = 64;
   localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int DATA_W = 32;

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_PROBE = 2'd2;

   localparam logic STATUS_FOUND   = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   // request travelling along the row of cells
   typedef struct packed {
      logic              active;
      logic              probe;
      logic [DATA_W-1:0] value;
      logic              dup;
      logic              hit;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
   } tok_type;

   // broadcast to every cell
   typedef struct packed {
      logic              clear;
      logic              ins;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] value;
   } cmd_type;

endpackage

/* design/set_intersection_engine.sv */
// Set intersection engine. Load requests fill a store of SET_CAPACITY distinct
// 32-bit values (duplicates ignored, lowest free entry used); a probe request
// whose value is stored returns it with status 0 and removes it, so each common
// value is reported once. A load of a new value into a full store comes back
// with status 1. A clear request empties the store; unused function codes
// are taken and ignored. The store is a row of SET_CAPACITY cells and a load
// or probe walks it one cell per cycle; the next request is taken only once
// such a request has left the row and any result has moved to the output
// register. The result sits in that register, and the engine goes on taking
// requests while it waits.
module set_intersection_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value_res
   output logic        rsp_tuser    // [0] status
);
   import sie_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_HOLD} state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_status_ff;
   logic [DATA_W-1:0] pend_value_ff;
   logic              pend_status_ff;

   tok_type           tok [SET_CAPACITY+1];
   tok_type           tail;
   cmd_type           cmd;
   logic              accept;
   logic              res_need;
   logic              out_free;
   logic              rsp_load;
   logic [SET_CAPACITY-1:0] busy_vec;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      tok[0]            = '0;
      tok[0].active     = accept && ((req_tuser == FUNC_LOAD) || (req_tuser == FUNC_PROBE));
      tok[0].probe      = (req_tuser == FUNC_PROBE);
      tok[0].value      = req_tdata;
   end

   genvar gi;
   generate
      for (gi = 0; gi < SET_CAPACITY; gi++) begin : g_cell
         sie_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (IDX_W'(gi)),
            .tok_i    (tok[gi]),
            .cmd_i    (cmd),
            .tok_o    (tok[gi+1])
         );
         assign busy_vec[gi] = tok[gi+1].active;
      end
   endgenerate

   assign tail = tok[SET_CAPACITY];

   // insert only once the whole row has been checked for a duplicate
   always_comb begin
      cmd.clear = accept && (req_tuser == FUNC_CLEAR);
      cmd.ins   = (state_ff == ST_WALK) && tail.active && !tail.probe &&
                  !tail.dup && tail.free_found;
      cmd.idx   = tail.free_idx;
      cmd.value = tail.value;
   end

   assign res_need = tail.active &&
                     (tail.probe ? tail.hit : (!tail.dup && !tail.free_found));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = ((state_ff == ST_WALK) && res_need && out_free) ||
                     ((state_ff == ST_HOLD) && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            ST_IDLE: begin
               if (tok[0].active) begin
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (tail.active) begin
                  if (res_need && out_free) begin
                     rsp_value_ff  <= tail.value;
                     rsp_status_ff <= tail.probe ? STATUS_FOUND : STATUS_DROPPED;
                     state_ff      <= ST_IDLE;
                  end else if (res_need) begin
                     // hold the result until the output register drains
                     pend_value_ff  <= tail.value;
                     pend_status_ff <= tail.probe ? STATUS_FOUND : STATUS_DROPPED;
                     state_ff       <= ST_HOLD;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_HOLD: begin
               if (out_free) begin
                  rsp_value_ff  <= pend_value_ff;
                  rsp_status_ff <= pend_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_vec) <= 1)
      else $error("more than one request in the cell row");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (busy_vec == '0))
      else $error("request in the cell row while idle");

   a_result_out: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && res_need && out_free) |=> rsp_valid_ff)
      else $error("result lost at end of walk");

   a_hold_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_HOLD) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("held result not delivered");

endmodule

/* design/sie_cell.sv */
module sie_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [sie_pkg::IDX_W-1:0] cell_idx,
   input  sie_pkg::tok_type         tok_i,
   input  sie_pkg::cmd_type         cmd_i,
   output sie_pkg::tok_type         tok_o
);
   import sie_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   tok_type           tok_ff;
   tok_type           tok_in;
   logic              match;

   assign match = tok_i.active && valid_ff && (value_ff == tok_i.value);

   always_comb begin
      tok_in   = tok_i;
      valid_in = valid_ff;
      value_in = value_ff;
      if (tok_i.active) begin
         if (tok_i.probe) begin
            // stored values are distinct, so at most one cell hits
            if (match) begin
               tok_in.hit = 1'b1;
               valid_in   = 1'b0;
            end
         end else begin
            if (match) begin
               tok_in.dup = 1'b1;
            end
            if (!valid_ff && !tok_i.free_found) begin
               tok_in.free_found = 1'b1;
               tok_in.free_idx   = cell_idx;
            end
         end
      end
      if (cmd_i.clear) begin
         valid_in = 1'b0;
      end else if (cmd_i.ins && (cmd_i.idx == cell_idx)) begin
         valid_in = 1'b1;
         value_in = cmd_i.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign tok_o = tok_ff;

endmodule
